// ===== rtl/bld_pkg.sv =====
package bld_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef logic signed [31:0] value_t;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DELETE     = 3'd4,
        OP_LIST_FWD   = 3'd5,
        OP_LIST_REV   = 3'd6
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NOTFOUND = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHL,
        CELL_SHR,
        CELL_LOAD
    } cell_op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t         op;
        logic [CNT_W-1:0] live;
        value_t           data;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DELETE,
        FSM_LIST
    } state_t;

endpackage

// ===== rtl/bld_cell.sv =====
module bld_cell import bld_pkg::*; (
    input  logic             aclk,
    input  logic [IDX_W-1:0] cell_idx,
    input  cell_cmd_t        cmd,
    input  value_t           left_value,
    input  value_t           right_value,
    output value_t           value
);

    value_t           value_reg;
    value_t           value_next;
    logic [CNT_W-1:0] pos;

    assign pos   = CNT_W'(cell_idx);
    assign value = value_reg;

    // Shift left moves toward the front; the cell at the live end takes the data.
    // Shift right moves toward the back; the front cell takes the data.
    always_comb begin
        value_next = value_reg;
        case (cmd.op)
            CELL_SHL: begin
                if (pos + CNT_W'(1) == cmd.live) begin
                    value_next = cmd.data;
                end else begin
                    value_next = right_value;
                end
            end
            CELL_SHR: begin
                if (pos == '0) begin
                    value_next = cmd.data;
                end else begin
                    value_next = left_value;
                end
            end
            CELL_LOAD: begin
                if (pos == cmd.live) begin
                    value_next = cmd.data;
                end
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule

// ===== rtl/bounded_list_deque_core.sv =====
// Channel   Ports                                   Direction  Carries
// input     s_valid s_ready s_opcode s_value         in         one request
// result    m_valid m_ready m_status m_entry_value   out        one result
//           m_is_last
//
// Pushes and pops: the request is accepted and its status is registered at
// the same edge. A delete walks the list once through the cell chain, one
// entry per cycle while the result channel is not stalled, and returns
// its status on the last step. A listing gives one result per cycle while
// the result channel is not stalled, one per stored entry. The walk
// length is the number of stored entries, at most CAPACITY.
// Reset (aresetn low at a clock edge) empties the list at once; the cell
// contents are not cleared. A stalled result channel holds the walk in place.

module bounded_list_deque_core import bld_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [2:0]    s_opcode,
    input  value_t        s_value,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [1:0]    m_status,
    output value_t        m_entry_value,
    output logic          m_is_last
);

    // The list is kept in order in a chain of cells: cell 0 is the front and
    // cell live_reg-1 the back. Walks rotate the chain so that the front (or
    // back) cell always shows the entry being visited; after a full walk the
    // original order is back in place.

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] step_reg, step_next;
    value_t           key_reg, key_next;
    logic             reverse_reg, reverse_next;
    logic             found_reg, found_next;

    logic             m_valid_reg, m_valid_next;
    status_t          m_status_reg, m_status_next;
    value_t           m_entry_value_reg, m_entry_value_next;
    logic             m_is_last_reg, m_is_last_next;

    cell_cmd_t        cmd;
    value_t           cell_value [CAPACITY];
    value_t           front_value;
    value_t           back_value;
    logic [CNT_W-1:0] back_pos;
    logic [IDX_W-1:0] back_idx;
    logic             out_free;
    logic             accept;
    logic             last_step;
    logic             emit;
    status_t          emit_status;
    value_t           emit_value;
    logic             emit_last;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            value_t left_in;
            value_t right_in;
            if (gi == 0) begin : g_first
                assign left_in = '0;
            end else begin : g_mid_l
                assign left_in = cell_value[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_in = '0;
            end else begin : g_mid_r
                assign right_in = cell_value[gi+1];
            end
            bld_cell u_cell (
                .aclk        (aclk),
                .cell_idx    (IDX_W'(gi)),
                .cmd         (cmd),
                .left_value  (left_in),
                .right_value (right_in),
                .value       (cell_value[gi])
            );
        end
    endgenerate

    assign back_pos    = live_reg - CNT_W'(1);
    assign back_idx    = back_pos[IDX_W-1:0];
    assign front_value = cell_value[0];
    assign back_value  = cell_value[back_idx];

    // The result register may be reloaded when it is empty or being taken.
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == FSM_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign last_step = (step_reg + CNT_W'(1) == total_reg);

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_value = m_entry_value_reg;
    assign m_is_last     = m_is_last_reg;

    always_comb begin
        state_next   = state_reg;
        live_next    = live_reg;
        total_next   = total_reg;
        step_next    = step_reg;
        key_next     = key_reg;
        reverse_next = reverse_reg;
        found_next   = found_reg;
        cmd.op       = CELL_HOLD;
        cmd.live     = live_reg;
        cmd.data     = s_value;
        emit         = 1'b0;
        emit_status  = STAT_OK;
        emit_value   = '0;
        emit_last    = 1'b1;

        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    unique case (s_opcode)
                        OP_PUSH_FRONT: begin
                            emit = 1'b1;
                            if (live_reg == CNT_W'(CAPACITY)) begin
                                emit_status = STAT_FULL;
                            end else begin
                                cmd.op    = CELL_SHR;
                                live_next = live_reg + CNT_W'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            emit = 1'b1;
                            if (live_reg == CNT_W'(CAPACITY)) begin
                                emit_status = STAT_FULL;
                            end else begin
                                cmd.op    = CELL_LOAD;
                                live_next = live_reg + CNT_W'(1);
                            end
                        end
                        OP_POP_FRONT: begin
                            emit = 1'b1;
                            if (live_reg == '0) begin
                                emit_status = STAT_EMPTY;
                            end else begin
                                cmd.op    = CELL_SHL;
                                live_next = live_reg - CNT_W'(1);
                            end
                        end
                        OP_POP_BACK: begin
                            emit = 1'b1;
                            if (live_reg == '0) begin
                                emit_status = STAT_EMPTY;
                            end else begin
                                live_next = live_reg - CNT_W'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (live_reg == '0) begin
                                emit        = 1'b1;
                                emit_status = STAT_EMPTY;
                            end else begin
                                key_next   = s_value;
                                total_next = live_reg;
                                step_next  = '0;
                                found_next = 1'b0;
                                state_next = FSM_DELETE;
                            end
                        end
                        OP_LIST_FWD: begin
                            if (live_reg == '0) begin
                                emit        = 1'b1;
                                emit_status = STAT_EMPTY;
                            end else begin
                                reverse_next = 1'b0;
                                total_next   = live_reg;
                                step_next    = '0;
                                state_next   = FSM_LIST;
                            end
                        end
                        OP_LIST_REV: begin
                            if (live_reg == '0) begin
                                emit        = 1'b1;
                                emit_status = STAT_EMPTY;
                            end else begin
                                reverse_next = 1'b1;
                                total_next   = live_reg;
                                step_next    = '0;
                                state_next   = FSM_LIST;
                            end
                        end
                        default: begin
                            // The unused opcode is dropped without a result.
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            FSM_DELETE: begin
                if (out_free) begin
                    // The front entry either rotates to the back or, on the
                    // first match, drops out of the chain.
                    cmd.op    = CELL_SHL;
                    step_next = step_reg + CNT_W'(1);
                    if (!found_reg && (front_value == key_reg)) begin
                        cmd.data   = '0;
                        live_next  = live_reg - CNT_W'(1);
                        found_next = 1'b1;
                    end else begin
                        cmd.data = front_value;
                    end
                    if (last_step) begin
                        emit        = 1'b1;
                        emit_status = found_next ? STAT_OK : STAT_NOTFOUND;
                        state_next  = FSM_IDLE;
                    end
                end
            end
            FSM_LIST: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_last = last_step;
                    step_next = step_reg + CNT_W'(1);
                    if (reverse_reg) begin
                        cmd.op     = CELL_SHR;
                        cmd.data   = back_value;
                        emit_value = back_value;
                    end else begin
                        cmd.op     = CELL_SHL;
                        cmd.data   = front_value;
                        emit_value = front_value;
                    end
                    if (last_step) begin
                        state_next = FSM_IDLE;
                    end
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase

        m_valid_next       = m_valid_reg && !m_ready;
        m_status_next      = m_status_reg;
        m_entry_value_next = m_entry_value_reg;
        m_is_last_next     = m_is_last_reg;
        if (emit) begin
            m_valid_next       = 1'b1;
            m_status_next      = emit_status;
            m_entry_value_next = emit_value;
            m_is_last_next     = emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg         <= total_next;
        step_reg          <= step_next;
        key_reg           <= key_next;
        reverse_reg       <= reverse_next;
        found_reg         <= found_next;
        m_status_reg      <= m_status_next;
        m_entry_value_reg <= m_entry_value_next;
        m_is_last_reg     <= m_is_last_next;
    end

    // The chain never holds more entries than it has cells.
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // A walk never runs past the number of entries it started with.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_DELETE || state_reg == FSM_LIST) |-> (step_reg < total_reg))
        else $error("walk step out of range");

    // A delete removes at most one entry.
    a_delete_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_DELETE) |->
            (live_reg == total_reg || live_reg + CNT_W'(1) == total_reg))
        else $error("delete removed more than one entry");

    // An accepted push into a list with room grows it by exactly one entry.
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_opcode == OP_PUSH_FRONT || s_opcode == OP_PUSH_BACK)
            && live_reg != CNT_W'(CAPACITY))
        |=> (live_reg == $past(live_reg) + CNT_W'(1)))
        else $error("push did not grow the list");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import bld_pkg::*;

    // Code 7 is not an operation; the block must swallow it without a result.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int NUM_ROWS        = 25;
    localparam int RANDOM_REQUESTS = 210;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 4 * CAPACITY + 8;

    // One row of the directed table. A row may repeat its request, with the
    // value stepping up by one each time. Where the outcome is obvious the
    // status is written into the row; otherwise the deque predictor decides.
    typedef struct packed {
        logic [2:0] op;
        value_t     value;
        logic [4:0] reps;
        logic       fixed;
        status_t    fixed_status;
    } stim_row_t;

    typedef struct {
        status_t status;
        value_t  entry;
        logic    last;
    } result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_opcode = OP_UNUSED;
    value_t     s_value = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_status;
    value_t     m_entry_value;
    logic       m_is_last;

    bounded_list_deque_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_value       (s_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_value (m_entry_value),
        .m_is_last     (m_is_last)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // The directed table. It starts on an empty list (every empty-list case),
    // touches the value extremes, fills the list to capacity so that a push
    // gets dropped, and then unlinks entries at the front, in the middle and
    // at the back before listing again.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{OP_LIST_FWD,   32'sh0000_0000,  5'd1, 1'b1, STAT_EMPTY},
        '{OP_LIST_REV,   32'sh0000_0000,  5'd1, 1'b1, STAT_EMPTY},
        '{OP_POP_FRONT,  32'sh0000_0000,  5'd1, 1'b1, STAT_EMPTY},
        '{OP_POP_BACK,   32'shFFFF_FFFF,  5'd1, 1'b1, STAT_EMPTY},
        '{OP_DELETE,     32'sh0000_0005,  5'd1, 1'b1, STAT_EMPTY},
        '{OP_UNUSED,     32'shFFFF_FFFF,  5'd1, 1'b0, STAT_OK},
        '{OP_PUSH_FRONT, 32'sh7FFF_FFFF,  5'd1, 1'b1, STAT_OK},
        '{OP_PUSH_BACK,  32'sh8000_0000,  5'd1, 1'b1, STAT_OK},
        '{OP_PUSH_FRONT, 32'shFFFF_FFFF,  5'd1, 1'b0, STAT_OK},
        '{OP_PUSH_BACK,  32'sh0000_0000,  5'd1, 1'b0, STAT_OK},
        '{OP_LIST_FWD,   32'sh0000_0000,  5'd1, 1'b0, STAT_OK},
        '{OP_LIST_REV,   32'sh0000_0000,  5'd1, 1'b0, STAT_OK},
        '{OP_DELETE,     32'sh1234_5678,  5'd1, 1'b1, STAT_NOTFOUND},
        '{OP_DELETE,     32'sh8000_0000,  5'd1, 1'b1, STAT_OK},
        '{OP_POP_FRONT,  32'sh0000_0000,  5'd1, 1'b1, STAT_OK},
        '{OP_PUSH_BACK,  32'sh0000_0064,  5'd14, 1'b0, STAT_OK},
        '{OP_PUSH_FRONT, 32'sh0000_0005,  5'd1, 1'b1, STAT_FULL},
        '{OP_PUSH_BACK,  32'sh0000_0006,  5'd1, 1'b1, STAT_FULL},
        '{OP_LIST_FWD,   32'sh0000_0000,  5'd1, 1'b0, STAT_OK},
        '{OP_LIST_REV,   32'sh0000_0000,  5'd1, 1'b0, STAT_OK},
        '{OP_DELETE,     32'sh0000_006B,  5'd1, 1'b0, STAT_OK},
        '{OP_DELETE,     32'sh7FFF_FFFF,  5'd1, 1'b0, STAT_OK},
        '{OP_POP_BACK,   32'sh0000_0000,  5'd1, 1'b0, STAT_OK},
        '{OP_LIST_FWD,   32'sh0000_0000,  5'd1, 1'b0, STAT_OK},
        '{OP_LIST_REV,   32'sh0000_0000,  5'd1, 1'b0, STAT_OK}
    };

    // Predictor state: the deque contents from front (index 0) to back. The
    // cell chain inside the block is not visible at the ports, so a plain
    // ordered queue of values predicts every result.
    value_t  deque_contents[$];
    result_t step_results[$];
    result_t expected_results[$];

    int errors         = 0;
    int requests_sent  = 0;
    int results_seen   = 0;
    int full_drops     = 0;
    int empty_hits     = 0;
    int deepest        = 0;
    int burst_left     = 0;

    // Works out the results one accepted request causes and updates the
    // predicted deque to match.
    task automatic predict_request(input logic [2:0] op, input value_t val);
        int n;
        int hit;
        step_results.delete();
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (deque_contents.size() >= CAPACITY) begin
                    step_results.push_back('{STAT_FULL, '0, 1'b1});
                end else begin
                    if (op == OP_PUSH_FRONT) deque_contents.push_front(val);
                    else deque_contents.push_back(val);
                    step_results.push_back('{STAT_OK, '0, 1'b1});
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (deque_contents.size() == 0) begin
                    step_results.push_back('{STAT_EMPTY, '0, 1'b1});
                end else begin
                    if (op == OP_POP_FRONT) void'(deque_contents.pop_front());
                    else void'(deque_contents.pop_back());
                    step_results.push_back('{STAT_OK, '0, 1'b1});
                end
            end
            OP_DELETE: begin
                // Only the first match, counted from the front, is unlinked.
                hit = -1;
                for (n = 0; n < deque_contents.size(); n++) begin
                    if (hit < 0 && deque_contents[n] == val) hit = n;
                end
                if (deque_contents.size() == 0) begin
                    step_results.push_back('{STAT_EMPTY, '0, 1'b1});
                end else if (hit < 0) begin
                    step_results.push_back('{STAT_NOTFOUND, '0, 1'b1});
                end else begin
                    deque_contents.delete(hit);
                    step_results.push_back('{STAT_OK, '0, 1'b1});
                end
            end
            OP_LIST_FWD, OP_LIST_REV: begin
                if (deque_contents.size() == 0) begin
                    step_results.push_back('{STAT_EMPTY, '0, 1'b1});
                end else begin
                    for (n = 0; n < deque_contents.size(); n++) begin
                        step_results.push_back('{STAT_OK,
                            (op == OP_LIST_FWD) ? deque_contents[n]
                                : deque_contents[deque_contents.size() - 1 - n],
                            (n == deque_contents.size() - 1)});
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // Presents one request and holds it until the block takes it. The sender
    // runs in bursts: when a burst is used up, valid drops for a random gap
    // (sometimes none) and a new burst length is drawn.
    task automatic issue_request(input logic [2:0] op, input value_t val,
                                 input logic fixed, input status_t fixed_status);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= val;
        do @(posedge aclk); while (!s_ready);

        predict_request(op, val);
        if (fixed) begin
            expected_results.push_back('{fixed_status, '0, 1'b1});
        end else begin
            foreach (step_results[k]) expected_results.push_back(step_results[k]);
        end
        foreach (step_results[k]) begin
            if (step_results[k].status == STAT_FULL) full_drops++;
            if (step_results[k].status == STAT_EMPTY) empty_hits++;
        end
        if (deque_contents.size() > deepest) deepest = deque_contents.size();
        requests_sent++;
    endtask

    // Draws a value: often a small pool so that duplicates and delete hits
    // are common, sometimes an entry already stored, an extreme, or any word.
    function automatic value_t pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) return value_t'($urandom_range(0, 7));
        if (sel < 60 && deque_contents.size() > 0)
            return deque_contents[$urandom_range(0, deque_contents.size() - 1)];
        if (sel < 72) begin
            case ($urandom_range(0, 3))
                0: return 32'sh7FFF_FFFF;
                1: return 32'sh8000_0000;
                2: return 32'shFFFF_FFFF;
                default: return 32'sh0000_0000;
            endcase
        end
        return value_t'($urandom);
    endfunction

    // Result side: every accepted result is compared with the oldest pending
    // expectation. The ready line follows a rotating 8-bit pattern that is
    // redrawn whenever the 6-bit tick counter wraps; a quarter of the time it is all ones, so there
    // are long stretches without back-pressure. Bit 0 is always set, which
    // bounds any stall to well under the time between redraws.
    logic [7:0] ready_pattern = 8'hFF;
    logic [5:0] ready_tick = '0;

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: status %0d value %0d last %0b",
                         $time, m_status, m_entry_value, m_is_last);
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_status);
                end
                if (m_entry_value !== want.entry) begin
                    errors++;
                    $display("%0t: entry_value expected %0d actual %0d",
                             $time, want.entry, m_entry_value);
                end
                if (m_is_last !== want.last) begin
                    errors++;
                    $display("%0t: is_last expected %0b actual %0b",
                             $time, want.last, m_is_last);
                end
            end
        end
        ready_tick <= ready_tick + 6'd1;
        if (ready_tick == 6'd63) begin
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 8'hFF
                                                         : (8'($urandom) | 8'h01);
        end else begin
            ready_pattern <= {ready_pattern[6:0], ready_pattern[7]};
        end
        m_ready <= ready_pattern[7];
    end

    // Watchdog: a run of cycles with no request and no result accepted means
    // the block has hung. The longest legitimate quiet stretch is a full
    // delete walk plus a sender gap plus a receiver stall, far below the limit.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles, %0d results still pending",
                 $time, STALL_LIMIT, expected_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence: reset, the directed table, then random traffic.
    initial begin : main_sequence
        int row;
        int rep;
        int sel;
        int sent;
        logic filling;
        logic [2:0] op;
        value_t val;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < NUM_ROWS; row++) begin
            for (rep = 0; rep < directed_rows[row].reps; rep++) begin
                issue_request(directed_rows[row].op, directed_rows[row].value + rep,
                              directed_rows[row].fixed, directed_rows[row].fixed_status);
            end
        end

        // Random traffic alternates between a filling mood, where pushes
        // dominate, and a draining mood, where pops do. The mood flips when
        // the list reaches an end, so the run keeps sweeping between empty
        // and full and hits both boundaries many times. Unused opcodes are
        // sprinkled in as noise and do not count toward the request total.
        filling = 1'b1;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            if (deque_contents.size() >= CAPACITY) filling = 1'b0;
            else if (deque_contents.size() == 0) filling = 1'b1;
            else if ($urandom_range(0, 39) == 0) filling = ~filling;

            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                op = OP_UNUSED;
            end else if (sel < (filling ? 58 : 20)) begin
                op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
            end else if (sel < (filling ? 72 : 70)) begin
                op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
            end else if (sel < 86) begin
                op = OP_DELETE;
            end else begin
                op = $urandom_range(0, 1) ? OP_LIST_FWD : OP_LIST_REV;
            end

            if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK || op == OP_DELETE)
                val = pick_value();
            else
                val = value_t'($urandom);

            issue_request(op, val, 1'b0, STAT_OK);
            if (op != OP_UNUSED) sent++;
        end
        s_valid <= 1'b0;

        // Let every pending result come back, then keep watching for a while
        // so that a stray extra result would still be caught.
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d results; the list reached depth %0d.",
                 requests_sent, results_seen, deepest);
        $display("Pushes dropped on a full list: %0d, requests that found it empty: %0d.",
                 full_drops, empty_hits);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bld_pkg.sv
rtl/bld_cell.sv
rtl/bounded_list_deque_core.sv
tb/testbench.sv
